>>> rtl/ubbe_pkg.sv
// Shared types and constants for the UART byte buffer engine.
// Used by the control, datapath and top modules and the testbench; no dependencies.
package ubbe_pkg;

    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 64;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);

    localparam int BYTE_W   = 8;
    localparam int IN_DW    = 16;
    localparam int IN_UW    = 3;
    localparam int OUT_DW   = 24;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 1;

    localparam logic [BYTE_W-1:0] CHAR_NL = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;

    typedef enum logic [IN_UW-1:0] {
        CMD_PUT        = 3'd0,
        CMD_GET        = 3'd1,
        CMD_PEEK       = 3'd2,
        CMD_RX_BYTE    = 3'd3,
        CMD_TX_DONE    = 3'd4,
        CMD_CTS_CHANGE = 3'd5
    } t_cmd;

    typedef enum logic [CFG_AW-1:0] {
        CFG_FLOW_CONTROL   = 1'b0,
        CFG_NEWLINE_EXPAND = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic latch;
        logic exec;
        logic put_cr;
        logic send;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic need_cr;
        logic out_free;
    } t_dp_status;

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] idx);
        return (idx == TX_AW'(TX_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] idx);
        return (idx == RX_AW'(RX_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

endpackage

>>> rtl/ubbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ubbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/ubbe_ctrl.sv
// Sequencing state machine for the UART byte buffer engine.
// Depends on ubbe_pkg; drives the datapath through t_dp_cmd.
module ubbe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  ubbe_pkg::t_dp_status i_status,
    output ubbe_pkg::t_dp_cmd    o_cmd
);
    import ubbe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PUT_CR,
        S_SEND,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_EXEC;
            S_EXEC:   n_state = i_status.need_cr ? S_PUT_CR : S_SEND;
            S_PUT_CR: n_state = S_SEND;
            S_SEND:   n_state = S_FIN;
            S_FIN:    if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready    = (r_state == S_IDLE);
    assign o_cmd.latch   = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.put_cr  = (r_state == S_PUT_CR);
    assign o_cmd.send    = (r_state == S_SEND);
    assign o_cmd.finish  = (r_state == S_FIN) && i_status.out_free;
endmodule

>>> rtl/ubbe_dp.sv
// Datapath: ring pointers, configuration, both byte rings and the result register.
// Depends on ubbe_pkg and ubbe_ram.
module ubbe_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ubbe_pkg::t_dp_cmd              i_cmd,
    output ubbe_pkg::t_dp_status           o_status,
    input  logic [ubbe_pkg::IN_DW-1:0]    i_s_tdata,
    input  logic [ubbe_pkg::IN_UW-1:0]    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ubbe_pkg::OUT_DW-1:0]   o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [ubbe_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [ubbe_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import ubbe_pkg::*;

    t_cmd              r_cmd;
    logic [BYTE_W-1:0] r_data;
    logic              r_cts;

    logic              r_flow_en;
    logic              r_nl_expand;

    logic [TX_AW-1:0]  r_tx_head, r_tx_tail;
    logic [RX_AW-1:0]  r_rx_head, r_rx_tail;
    logic              r_line_busy;

    logic              r_read_valid;
    logic              r_accepted;
    logic              r_dropped;
    logic              r_send_valid;
    logic [BYTE_W-1:0] r_read_byte;

    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;

    logic              need2, fits1, fits2, fits;
    logic              rx_nonempty, rx_full, send_ok;
    logic              is_put, is_rd;
    logic [TX_AW-1:0]  tx_tail_nx, tx_head_nx;
    logic [RX_AW-1:0]  rx_tail_nx, rx_head_nx;

    logic              tx_we, tx_re, rx_we, rx_re;
    logic [BYTE_W-1:0] tx_wdata, tx_rdata, rx_rdata;
    logic [BYTE_W-1:0] send_byte;

    assign tx_tail_nx  = tx_next(r_tx_tail);
    assign tx_head_nx  = tx_next(r_tx_head);
    assign rx_tail_nx  = rx_next(r_rx_tail);
    assign rx_head_nx  = rx_next(r_rx_head);

    assign is_put      = (r_cmd == CMD_PUT);
    assign is_rd       = (r_cmd == CMD_GET) || (r_cmd == CMD_PEEK);
    assign need2       = r_nl_expand && (r_data == CHAR_NL);
    assign fits1       = (tx_tail_nx != r_tx_head);
    assign fits2       = fits1 && (tx_next(tx_tail_nx) != r_tx_head);
    assign fits        = need2 ? fits2 : fits1;
    assign rx_nonempty = (r_rx_head != r_rx_tail);
    assign rx_full     = (rx_tail_nx == r_rx_head);
    assign send_ok     = !r_line_busy && (r_tx_head != r_tx_tail) && (!r_flow_en || r_cts);

    assign o_status.need_cr  = is_put && need2 && fits2;
    assign o_status.out_free = !r_out_valid || i_m_tready;

    assign tx_we    = (i_cmd.exec && is_put && fits) || i_cmd.put_cr;
    assign tx_wdata = i_cmd.put_cr ? CHAR_CR : r_data;
    assign tx_re    = i_cmd.send && send_ok;
    assign rx_we    = i_cmd.exec && (r_cmd == CMD_RX_BYTE) && !rx_full;
    assign rx_re    = i_cmd.exec && is_rd && rx_nonempty;

    ubbe_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_tail),
        .i_wdata (tx_wdata),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    ubbe_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_tail),
        .i_wdata (r_data),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    assign send_byte = r_send_valid ? tx_rdata : '0;

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= t_cmd'(i_s_tuser);
            r_data <= i_s_tdata[BYTE_W-1:0];
            r_cts  <= i_s_tdata[BYTE_W];
        end
        if (i_cmd.send) begin
            r_read_byte <= r_read_valid ? rx_rdata : '0;
        end
        if (i_cmd.finish) begin
            r_out_data <= {3'b000,
                           (r_tx_head == r_tx_tail),
                           send_byte,
                           r_send_valid,
                           r_dropped,
                           r_accepted,
                           r_read_valid,
                           r_read_byte};
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_en    <= 1'b0;
            r_nl_expand  <= 1'b1;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_rx_head    <= '0;
            r_rx_tail    <= '0;
            r_line_busy  <= 1'b0;
            r_read_valid <= 1'b0;
            r_accepted   <= 1'b0;
            r_dropped    <= 1'b0;
            r_send_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_FLOW_CONTROL:   r_flow_en   <= i_cfg_wdata[0];
                    CFG_NEWLINE_EXPAND: r_nl_expand <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_cmd.latch) begin
                r_read_valid <= 1'b0;
                r_accepted   <= 1'b0;
                r_dropped    <= 1'b0;
                r_send_valid <= 1'b0;
            end

            if (i_cmd.exec) begin
                case (r_cmd)
                    CMD_PUT: begin
                        if (fits) begin
                            r_tx_tail  <= tx_tail_nx;
                            r_accepted <= 1'b1;
                        end
                    end
                    CMD_GET, CMD_PEEK: begin
                        if (rx_nonempty) begin
                            r_read_valid <= 1'b1;
                            if (r_cmd == CMD_GET) begin
                                r_rx_head <= rx_head_nx;
                            end
                        end
                    end
                    CMD_RX_BYTE: begin
                        if (rx_full) begin
                            r_dropped <= 1'b1;
                        end else begin
                            r_rx_tail <= rx_tail_nx;
                        end
                    end
                    CMD_TX_DONE: r_line_busy <= 1'b0;
                    default: ;
                endcase
            end

            if (i_cmd.put_cr) begin
                r_tx_tail <= tx_tail_nx;
            end

            if (i_cmd.send && send_ok) begin
                r_tx_head    <= tx_head_nx;
                r_line_busy  <= 1'b1;
                r_send_valid <= 1'b1;
            end

            priority if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
endmodule

>>> rtl/uart_byte_buffer_engine_unit.sv
// Top level of the UART byte buffer engine: transmit and receive byte rings.
// Depends on ubbe_pkg, ubbe_ctrl, ubbe_dp (which holds two ubbe_ram instances).
//
// Each input transfer carries one event (put, get, peek, line byte received,
// transmit done, clear-to-send change) and yields exactly one result transfer.
// The sequencer steps each event, in order, through event execution, an extra
// ring write for the carriage return (only for a put of a newline that expands
// into newline plus carriage return), the send attempt (one read of the transmit
// ring, registered) and result capture into the output register. The input is
// ready again in the cycle after the result is captured, so a new event is not
// taken before the previous one is through. The next event is accepted while the
// previous result still waits in the output register; result capture then
// holds until that result is taken. Each ring holds one byte fewer than its
// depth; both rings need no clearing after reset. The user must see that
// configuration is written only while idle; the block itself does not enforce it.
module uart_byte_buffer_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] data_byte, [8] clear_to_send, [15:9] zero
    input  logic [ubbe_pkg::IN_DW-1:0]    i_s_tdata,
    // [2:0] cmd
    input  logic [ubbe_pkg::IN_UW-1:0]    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] read_byte, [8] read_valid, [9] put_accepted, [10] rx_dropped,
    // [11] line_send_valid, [19:12] line_send_byte, [20] tx_empty, [23:21] zero
    output logic [ubbe_pkg::OUT_DW-1:0]   o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [ubbe_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [ubbe_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import ubbe_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    ubbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    ubbe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );
endmodule

>>> tb/ubbe_checker.sv
// Scoreboard for the UART byte buffer engine: mirrors both byte rings, the line
// state and the two registers, and compares each result transfer with its prediction.
// Depends on ubbe_pkg.
module ubbe_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    // [7:0] data_byte, [8] clear_to_send, [15:9] zero
    input  logic [ubbe_pkg::IN_DW-1:0]  i_s_tdata,
    // [2:0] cmd
    input  logic [ubbe_pkg::IN_UW-1:0]  i_s_tuser,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    // [7:0] read_byte, [8] read_valid, [9] put_accepted, [10] rx_dropped,
    // [11] line_send_valid, [19:12] line_send_byte, [20] tx_empty, [23:21] zero
    input  logic [ubbe_pkg::OUT_DW-1:0] i_m_tdata,
    input  logic                        i_cfg_we,
    input  logic [ubbe_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [ubbe_pkg::CFG_DW-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import ubbe_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
        logic              put_accepted;
        logic              rx_dropped;
        logic              send_valid;
        logic [BYTE_W-1:0] send_byte;
        logic              tx_empty;
    } t_ring_result;

    t_ring_result      ring_results[$];
    logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
    logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
    int                tx_rd;
    int                tx_wr;
    int                rx_rd;
    int                rx_wr;
    logic              line_busy;
    logic              flow_on;
    logic              nl_expand;
    int                mismatches = 0;

    task automatic push_tx(input logic [BYTE_W-1:0] b);
        tx_ring[tx_wr] = b;
        tx_wr = (tx_wr + 1) % TX_DEPTH;
    endtask

    task automatic step_rings(input logic [IN_UW-1:0] cmd, input logic [BYTE_W-1:0] data,
                              input logic cts, output t_ring_result r);
        int need;
        int room;
        r = '0;
        case (cmd)
            CMD_PUT: begin
                need = (nl_expand && data == CHAR_NL) ? 2 : 1;
                room = TX_DEPTH - 1 - (tx_wr - tx_rd + TX_DEPTH) % TX_DEPTH;
                if (need <= room) begin
                    push_tx(data);
                    if (need == 2) begin
                        push_tx(CHAR_CR);
                    end
                    r.put_accepted = 1'b1;
                end
            end
            CMD_GET, CMD_PEEK: begin
                if (rx_rd != rx_wr) begin
                    r.read_byte  = rx_ring[rx_rd];
                    r.read_valid = 1'b1;
                    if (cmd == CMD_GET) begin
                        rx_rd = (rx_rd + 1) % RX_DEPTH;
                    end
                end
            end
            CMD_RX_BYTE: begin
                if ((rx_wr + 1) % RX_DEPTH == rx_rd) begin
                    r.rx_dropped = 1'b1;
                end else begin
                    rx_ring[rx_wr] = data;
                    rx_wr = (rx_wr + 1) % RX_DEPTH;
                end
            end
            CMD_TX_DONE: begin
                line_busy = 1'b0;
            end
            default: begin
            end
        endcase
        // send attempt closes every event
        if (!line_busy && tx_rd != tx_wr && (!flow_on || cts)) begin
            r.send_valid = 1'b1;
            r.send_byte  = tx_ring[tx_rd];
            tx_rd = (tx_rd + 1) % TX_DEPTH;
            line_busy = 1'b1;
        end
        r.tx_empty = (tx_rd == tx_wr);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_ring_result want;
        t_ring_result got;
        if (!i_rst_n) begin
            ring_results.delete();
            tx_rd     = 0;
            tx_wr     = 0;
            rx_rd     = 0;
            rx_wr     = 0;
            line_busy = 1'b0;
            flow_on   = 1'b0;
            nl_expand = 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FLOW_CONTROL:   flow_on   = i_cfg_wdata[0];
                    CFG_NEWLINE_EXPAND: nl_expand = i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.read_byte    = i_m_tdata[7:0];
                got.read_valid   = i_m_tdata[8];
                got.put_accepted = i_m_tdata[9];
                got.rx_dropped   = i_m_tdata[10];
                got.send_valid   = i_m_tdata[11];
                got.send_byte    = i_m_tdata[19:12];
                got.tx_empty     = i_m_tdata[20];
                if (ring_results.size() == 0) begin
                    $error("result transfer with no event outstanding");
                    mismatches++;
                end else begin
                    want = ring_results.pop_front();
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("read_valid", want.read_valid, got.read_valid);
                    check_field("put_accepted", want.put_accepted, got.put_accepted);
                    check_field("rx_dropped", want.rx_dropped, got.rx_dropped);
                    check_field("line_send_valid", want.send_valid, got.send_valid);
                    check_field("line_send_byte", want.send_byte, got.send_byte);
                    check_field("tx_empty", want.tx_empty, got.tx_empty);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_rings(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8], want);
                ring_results.push_back(want);
            end
        end
        o_pending    <= ring_results.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/tb_uart_byte_buffer_engine_unit.sv
// Testbench top for uart_byte_buffer_engine_unit: drives directed and burst-shaped
// random events under several register settings and stall patterns.
// Depends on ubbe_pkg, ubbe_checker and the block under test.
module tb_uart_byte_buffer_engine_unit;
    import ubbe_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_EVENTS   = 175;
    localparam int NUM_PHASES     = 6;

    localparam logic [IN_UW-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [IN_UW-1:0] CMD_SPARE_7 = 3'd7;

    typedef enum int {
        BURST_FILL_TX,
        BURST_DRAIN_TX,
        BURST_FILL_RX,
        BURST_DRAIN_RX,
        BURST_MIXED,
        BURST_NOISE
    } t_burst;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata   = '0;
    logic [IN_UW-1:0]  s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    int                fail_count;
    int                pending;

    int offer_gap_pct  = 13;
    int ready_gap_pct  = 80;
    int stall_request  = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    always #5 clk = ~clk;

    uart_byte_buffer_engine_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    ubbe_checker scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= ready_gap_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_uart_byte_buffer_engine_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(input logic [IN_UW-1:0] cmd, input logic [7:0] data,
                              input logic cts);
        while ($urandom_range(99) < offer_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, cts, data};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_event(input t_burst kind, output bit counted);
        int               r;
        logic [IN_UW-1:0] cmd;
        logic [7:0]       data;
        r = $urandom_range(99);
        case (kind)
            BURST_FILL_TX:  cmd = (r < 85) ? CMD_PUT : (r < 92) ? CMD_TX_DONE : CMD_GET;
            BURST_DRAIN_TX: cmd = (r < 60) ? CMD_TX_DONE : (r < 80) ? CMD_CTS_CHANGE : CMD_PUT;
            BURST_FILL_RX:  cmd = (r < 85) ? CMD_RX_BYTE : (r < 95) ? CMD_PEEK : CMD_GET;
            BURST_DRAIN_RX: cmd = (r < 45) ? CMD_GET : (r < 70) ? CMD_PEEK : CMD_RX_BYTE;
            BURST_MIXED:    cmd = IN_UW'($urandom_range(CMD_CTS_CHANGE));
            default:        cmd = IN_UW'($urandom_range(7));
        endcase
        data = ($urandom_range(4) == 0) ? CHAR_NL : 8'($urandom_range(255));
        send_event(cmd, data, $urandom_range(99) < 65);
        counted = (cmd <= CMD_CTS_CHANGE);
    endtask

    task automatic random_traffic(input int count);
        int     sent;
        int     len;
        bit     counted;
        t_burst kind;
        sent = 0;
        while (sent < count) begin
            kind = t_burst'($urandom_range(BURST_NOISE));
            len  = $urandom_range(4, 80);
            for (int k = 0; k < len && sent < count; k++) begin
                random_event(kind, counted);
                if (counted) begin
                    sent++;
                end
            end
        end
    endtask

    initial begin
        bit phase_flow [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        bit phase_nl   [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        int phase_offer[NUM_PHASES] = '{13, 13, 80, 80, 0, 0};
        int phase_ready[NUM_PHASES] = '{80, 80, 13, 13, 0, 0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(CFG_FLOW_CONTROL, 1'b0);
        write_reg(CFG_NEWLINE_EXPAND, 1'b1);

        // empty receive ring, newline expansion, byte extremes, spare commands
        send_event(CMD_GET, 8'h00, 1'b0);
        send_event(CMD_PEEK, 8'hFF, 1'b0);
        send_event(CMD_PUT, 8'h00, 1'b0);
        send_event(CMD_PUT, CHAR_NL, 1'b0);
        send_event(CMD_PUT, 8'hFF, 1'b1);
        send_event(CMD_TX_DONE, 8'h00, 1'b0);
        send_event(CMD_RX_BYTE, 8'h00, 1'b0);
        send_event(CMD_RX_BYTE, 8'hFF, 1'b1);
        send_event(CMD_PEEK, 8'h00, 1'b0);
        send_event(CMD_GET, 8'h00, 1'b0);
        send_event(CMD_GET, 8'h00, 1'b0);
        send_event(CMD_GET, 8'h00, 1'b0);
        send_event(CMD_CTS_CHANGE, 8'h00, 1'b1);
        send_event(CMD_SPARE_6, 8'hAA, 1'b1);
        send_event(CMD_SPARE_7, 8'h55, 1'b0);
        send_event(CMD_TX_DONE, 8'h00, 1'b1);
        send_event(CMD_TX_DONE, 8'h00, 1'b1);
        send_event(CMD_TX_DONE, 8'h00, 1'b1);
        send_event(CMD_TX_DONE, 8'h00, 1'b1);
        wait_idle();

        // flow control on, newline stored as is; done while idle
        write_reg(CFG_FLOW_CONTROL, 1'b1);
        write_reg(CFG_NEWLINE_EXPAND, 1'b0);
        send_event(CMD_PUT, CHAR_NL, 1'b0);
        send_event(CMD_TX_DONE, 8'h00, 1'b0);
        send_event(CMD_CTS_CHANGE, 8'h00, 1'b1);
        send_event(CMD_PUT, CHAR_CR, 1'b1);
        send_event(CMD_TX_DONE, 8'h00, 1'b1);
        send_event(CMD_TX_DONE, 8'h00, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_reg(CFG_FLOW_CONTROL, phase_flow[p]);
            write_reg(CFG_NEWLINE_EXPAND, phase_nl[p]);
            offer_gap_pct = phase_offer[p];
            ready_gap_pct = phase_ready[p];
            if (p == 4) begin
                stall_request = LONG_STALL;
            end
            random_traffic(PHASE_EVENTS);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_uart_byte_buffer_engine_unit passed");
        end else begin
            $display("tb_uart_byte_buffer_engine_unit failed");
        end
        $finish;
    end

endmodule
